[hw/rtl/tkb_pkg.sv]
// Shared types, sizes and register codes for the streaming top-K selector.
// Used by tkb_cell, tkb_emit and streaming_top_k_with_bias.
package tkb_pkg;

	localparam int MAX_KEPT  = 16;
	localparam int ROW_MAX   = 131072;
	localparam int SCORE_W   = 32;
	localparam int POS_W     = $clog2(ROW_MAX);
	localparam int TOKEN_W   = 18;
	localparam int NB_W      = 4;
	localparam int KCNT_W    = $clog2(MAX_KEPT + 1);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BEAMS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_OFFSET = 1'd1;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(ROW_MAX - 1);

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// One kept (score, position) pair with its valid flag.
	typedef struct packed {
		logic                      valid;
		logic signed [SCORE_W-1:0] score;
		logic [POS_W-1:0]          pos;
	} kept_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;    // a row element is being inserted
		logic shift;  // the chain moves one place towards cell 0
	} cell_ctl_t;

endpackage

[hw/rtl/tkb_cell.sv]
// One cell of the sorted candidate chain: holds a single kept pair.
// Depends on tkb_pkg for kept_t and cell_ctl_t.
module tkb_cell import tkb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_ctl_t                 ctl,
	input  logic                      keep_en,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [POS_W-1:0]          new_pos,
	input  kept_t                     prev_entry,
	input  logic                      prev_take,
	input  kept_t                     next_entry,
	output kept_t                     entry,
	output logic                      take
);

	kept_t ent_q;
	kept_t ent_d;
	logic  above;

	// The new element ranks above this entry: higher score, or equal score and
	// higher position.
	assign above = (new_score > ent_q.score) ||
		((new_score == ent_q.score) && (new_pos > ent_q.pos));
	assign take  = !ent_q.valid || above;

	always_comb begin
		ent_d = ent_q;
		if (ctl.ins) begin
			if (prev_take) begin
				ent_d.score = prev_entry.score;
				ent_d.pos   = prev_entry.pos;
			end else if (take) begin
				ent_d.score = new_score;
				ent_d.pos   = new_pos;
			end
			ent_d.valid = (ent_q.valid || prev_entry.valid) && keep_en;
		end else if (ctl.shift) begin
			ent_d = next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	assign entry = ent_q;

endmodule

[hw/rtl/tkb_emit.sv]
// Result stage: adds the beam score with saturation and the token offset.
// Depends on tkb_pkg for kept_t and the field widths.
module tkb_emit import tkb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  kept_t                     head,
	input  logic                      head_is_last,
	input  logic signed [SCORE_W-1:0] bias,
	input  logic [TOKEN_W-1:0]        offset,
	output logic                      result_valid,
	output logic signed [SCORE_W-1:0] score,
	output logic [TOKEN_W-1:0]        token_id,
	output logic                      last_result
);

	logic signed [SCORE_W:0]   sum;
	logic signed [SCORE_W-1:0] sat;

	assign sum = {head.score[SCORE_W-1], head.score} + {bias[SCORE_W-1], bias};

	// The top two bits of the widened sum differ exactly when it overflowed.
	always_comb begin
		if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			sat = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			sat = sum[SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			score       <= sat;
			token_id    <= TOKEN_W'(head.pos) + offset;
			last_result <= head_is_last;
		end
	end

endmodule

[hw/rtl/streaming_top_k_with_bias.sv]
// Top level of the streaming top-K selector with beam-score bias.
// Depends on tkb_pkg, tkb_cell and tkb_emit.
//
//   Channel   Handshake            Beat contents
//   -------   ------------------   ----------------------------------------
//   input     start, busy          log_prob, beam_score, last_in_row
//   result    result_valid         score, token_id, last_result
//   config    cfg_we               cfg_index, cfg_data
//
// A row element is taken while start is high and busy is low, so a row streams at
// one beat per clock while busy stays low. The element marked last_in_row is
// inserted like the others; busy then rises, also when nothing was kept, and stays
// high while the kept winners leave the head of the cell chain one at a time. Each
// result beat appears in the cycle after its winner sits at the head. Results cannot be
// stalled: each is shown for exactly one cycle. Reset empties the chain and
// restores the beam count to 2 and token_offset to 0.
module streaming_top_k_with_bias import tkb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [SCORE_W-1:0] log_prob,
	input  logic signed [SCORE_W-1:0] beam_score,
	input  logic                      last_in_row,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output logic                      result_valid,
	output logic signed [SCORE_W-1:0] score,
	output logic [TOKEN_W-1:0]        token_id,
	output logic                      last_result
);

	// Configuration registers.
	logic [NB_W-1:0]    beam_cnt_q;
	logic [TOKEN_W-1:0] token_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_cnt_q     <= NB_W'(2);
			token_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_BEAMS:    beam_cnt_q     <= cfg_data[NB_W-1:0];
				CFG_TOKEN_OFFSET: token_offset_q <= cfg_data[TOKEN_W-1:0];
				default:          ;
			endcase
		end
	end

	// The number of kept candidates is twice the beam count, capped at the
	// length of the chain.
	logic [KCNT_W:0]   k_raw;
	logic [KCNT_W-1:0] k_lim;

	assign k_raw = (KCNT_W + 1)'({beam_cnt_q, 1'b0});
	assign k_lim = (k_raw > (KCNT_W + 1)'(MAX_KEPT)) ? KCNT_W'(MAX_KEPT) : k_raw[KCNT_W-1:0];

	// Control state machine.
	state_t    state_q;
	state_t    state_d;
	logic      accept;
	logic      fire;
	cell_ctl_t ctl;
	kept_t     ent   [MAX_KEPT];
	logic      take  [MAX_KEPT];
	logic [MAX_KEPT-1:0] vld;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (start && last_in_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// Leave once the entry now at the head is the final one, or
				// when nothing was kept at all.
				if (!vld[0] || !vld[1]) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		busy      = (state_q == ST_DRAIN);
		accept    = start && (state_q == ST_FILL);
		ctl.ins   = accept;
		ctl.shift = (state_q == ST_DRAIN);
		fire      = (state_q == ST_DRAIN) && vld[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Position of the next element in the row, saturating at the last index.
	logic [POS_W-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last_in_row) begin
				pos_q <= '0;
			end else if (pos_q != POS_LAST) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// The beam score is captured with the final element and applied to every
	// winner of the row.
	logic signed [SCORE_W-1:0] bias_q;

	always_ff @(posedge clk) begin
		if (accept && last_in_row) begin
			bias_q <= beam_score;
		end
	end

	// The chain of cells, kept sorted best-first. On an insert every cell after
	// the insertion point takes its upper neighbour's pair, and the first cell
	// that is empty or whose entry the element beats takes the element itself.
	// While draining, pairs move one cell towards the head each cycle.
	kept_t head_src;
	kept_t tail_src;

	assign head_src = '{valid: 1'b1, score: log_prob, pos: pos_q};
	assign tail_src = '{valid: 1'b0, score: '0, pos: '0};

	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		tkb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.keep_en    (KCNT_W'(i) < k_lim),
			.new_score  (log_prob),
			.new_pos    (pos_q),
			.prev_entry ((i == 0) ? head_src : ent[(i == 0) ? 0 : i - 1]),
			.prev_take  ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
			.next_entry ((i == MAX_KEPT - 1) ? tail_src : ent[(i == MAX_KEPT - 1) ? i : i + 1]),
			.entry      (ent[i]),
			.take       (take[i])
		);
		assign vld[i] = ent[i].valid;
	end

	tkb_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.head         (ent[0]),
		.head_is_last (!vld[1]),
		.bias         (bias_q),
		.offset       (token_offset_q),
		.result_valid (result_valid),
		.score        (score),
		.token_id     (token_id),
		.last_result  (last_result)
	);

`ifndef SYNTHESIS
	// Valid entries always form a prefix of the chain.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld} + (MAX_KEPT + 1)'(1)))
		else $error("kept entries do not form a prefix");

	// A result beat only follows a cycle of draining.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat outside a drain");

	// Once draining ends the chain is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (vld == '0))
		else $error("chain not empty after drain");

	// The final winner of a row is not followed at once by another beat.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> !result_valid)
		else $error("result beat after the final winner");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for streaming_top_k_with_bias: a directed table, then random rows.
// Depends on tkb_pkg and the selector RTL; each result beat is checked against a predictor or typed row.

module tb;
	import tkb_pkg::*;

	localparam int RESULT_CAP     = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 256;
	// Cycles allowed after busy falls before a register write, covering a row that kept nothing.
	localparam int DRAIN_SETTLE   = 6;
	localparam int END_SETTLE     = 20;

	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic [TOKEN_W-1:0]        token_id;
		logic                      last;
	} winner_t;

	typedef enum {STIM_ITEM, STIM_CFG} stim_kind_t;

	// One line of the directed table: either a row element or a register write.
	typedef struct {
		stim_kind_t                kind;
		logic signed [SCORE_W-1:0] log_prob;
		logic signed [SCORE_W-1:0] beam_score;
		logic                      last;
		logic [CFG_IDX_W-1:0]      reg_index;
		logic [CFG_W-1:0]          reg_data;
		bit                        typed;
		winner_t                   winner;
	} stim_row_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      start       = 1'b0;
	logic signed [SCORE_W-1:0] log_prob    = '0;
	logic signed [SCORE_W-1:0] beam_score  = '0;
	logic                      last_in_row = 1'b0;
	logic                      cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index   = '0;
	logic [CFG_W-1:0]          cfg_data    = '0;
	logic                      busy;
	logic                      result_valid;
	logic signed [SCORE_W-1:0] score;
	logic [TOKEN_W-1:0]        token_id;
	logic                      last_result;

	streaming_top_k_with_bias DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.log_prob     (log_prob),
		.beam_score   (beam_score),
		.last_in_row  (last_in_row),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.score        (score),
		.token_id     (token_id),
		.last_result  (last_result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: a shadow copy of the kept list, the row position and the
	// two registers. Entries are only ever read behind their valid flag.
	// ------------------------------------------------------------------
	logic [NB_W-1:0]           beams_reg  = 4'd2;
	logic [TOKEN_W-1:0]        offset_reg = '0;
	logic signed [SCORE_W-1:0] kept_score [MAX_KEPT];
	logic [POS_W-1:0]          kept_pos   [MAX_KEPT];
	bit                        kept_ok    [MAX_KEPT];
	logic [POS_W-1:0]          row_pos    = '0;
	winner_t                   winners_due [$];
	winner_t                   no_winner;

	// Number of winners kept: twice the beam count, capped by the store and the result limit.
	function automatic int kept_limit();
		int k;
		k = 2 * int'(beams_reg);
		if (k > MAX_KEPT)
			k = MAX_KEPT;
		if (k > RESULT_CAP)
			k = RESULT_CAP;
		return k;
	endfunction

	function automatic int filled();
		int n = 0;
		while (n < MAX_KEPT && kept_ok[n])
			n++;
		return n;
	endfunction

	// Higher score wins; on equal scores the later position wins.
	function automatic bit outranks(input logic signed [SCORE_W-1:0] s, input logic [POS_W-1:0] p,
			input logic signed [SCORE_W-1:0] ks, input logic [POS_W-1:0] kp);
		if (s != ks)
			return s > ks;
		return p > kp;
	endfunction

	function automatic void rank_insert(input logic signed [SCORE_W-1:0] s,
			input logic [POS_W-1:0] p, input int k);
		int n;
		int i;
		int nn;
		n = filled();
		if (n > k)
			n = k;
		// Entries beyond the current K are dropped, which matters after a mid-row change.
		for (int j = n; j < MAX_KEPT; j++)
			kept_ok[j] = 1'b0;
		if (k == 0)
			return;
		i = 0;
		while (i < n && !outranks(s, p, kept_score[i], kept_pos[i]))
			i++;
		if (i >= k)
			return;
		nn = (n + 1 > k) ? k : n + 1;
		for (int j = nn - 1; j > i; j--) begin
			kept_score[j] = kept_score[j-1];
			kept_pos[j]   = kept_pos[j-1];
		end
		kept_score[i] = s;
		kept_pos[i]   = p;
		for (int j = 0; j < nn; j++)
			kept_ok[j] = 1'b1;
	endfunction

	function automatic logic signed [SCORE_W-1:0] add_sat(input logic signed [SCORE_W-1:0] a,
			input logic signed [SCORE_W-1:0] b);
		logic [SCORE_W:0] sum;
		sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
		case (sum[SCORE_W:SCORE_W-1])
			2'b01: return {1'b0, {(SCORE_W-1){1'b1}}};
			2'b10: return {1'b1, {(SCORE_W-1){1'b0}}};
			default: return sum[SCORE_W-1:0];
		endcase
	endfunction

	// Takes one accepted row element; on the last one, queues the winners best-first.
	function automatic void predict_beat(input logic signed [SCORE_W-1:0] lp,
			input logic signed [SCORE_W-1:0] bs, input logic last);
		int k;
		int n;
		winner_t w;
		k = kept_limit();
		rank_insert(lp, row_pos, k);
		if (row_pos < POS_LAST)
			row_pos++;
		if (!last)
			return;
		n = filled();
		if (n > k)
			n = k;
		for (int i = 0; i < n; i++) begin
			w.score    = add_sat(kept_score[i], bs);
			w.token_id = TOKEN_W'(kept_pos[i]) + offset_reg;
			w.last     = (i == n - 1);
			winners_due = {winners_due, w};
		end
		for (int i = 0; i < MAX_KEPT; i++)
			kept_ok[i] = 1'b0;
		row_pos = '0;
	endfunction

	// ------------------------------------------------------------------
	// Sender side. start_on mirrors the value last scheduled on start, so
	// that start is never given two assignments within one time step.
	// ------------------------------------------------------------------
	bit start_on    = 1'b0;
	int burst_left  = 0;
	int items_sent  = 0;

	task automatic lower_start();
		if (start_on) begin
			start    <= 1'b0;
			start_on  = 1'b0;
		end
	endtask

	// Presents one beat and holds it until the block takes it.
	task automatic send_beat(input logic signed [SCORE_W-1:0] lp,
			input logic signed [SCORE_W-1:0] bs, input logic last, input bit typed,
			input winner_t w);
		int queued;
		start       <= 1'b1;
		log_prob    <= lp;
		beam_score  <= bs;
		last_in_row <= last;
		start_on     = 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		queued = winners_due.size();
		predict_beat(lp, bs, last);
		// A typed row replaces the predicted winner with the one written in the table.
		if (typed) begin
			while (winners_due.size() > queued)
				winners_due.delete(winners_due.size() - 1);
			winners_due = {winners_due, w};
		end
		items_sent++;
	endtask

	// Bursts of random length, random gaps between them, and now and then a long unbroken stretch.
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			lower_start();
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
		end
	endtask

	task automatic wait_drained();
		lower_start();
		do begin
			@(posedge clk);
		end while (busy || winners_due.size() != 0);
	endtask

	// Register writes happen only with the block idle and every expected beat delivered.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wait_drained();
		repeat (DRAIN_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_NUM_BEAMS)
			beams_reg = data[NB_W-1:0];
		else
			offset_reg = data[TOKEN_W-1:0];
	endtask

	// ------------------------------------------------------------------
	// Random value pickers, weighted towards the edges of each field.
	// ------------------------------------------------------------------
	function automatic logic [CFG_W-1:0] pick_beams();
		logic [NB_W-1:0] b;
		case ($urandom_range(0, 9))
			0: b = '0;
			1: b = NB_W'(1);
			2: b = NB_W'($urandom_range(9, 15));
			default: b = NB_W'($urandom_range(2, 8));
		endcase
		// The bits above the beam count are junk and must be ignored.
		return (CFG_W'($urandom) & ~CFG_W'({NB_W{1'b1}})) | CFG_W'(b);
	endfunction

	function automatic logic [CFG_W-1:0] pick_offset();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return {CFG_W{1'b1}};
			2: return {CFG_W{1'b1}} - CFG_W'($urandom_range(0, 40));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [SCORE_W-1:0] pick_score(input int style);
		case (style)
			0: return SCORE_W'($urandom);
			1: return SCORE_W'(int'($urandom_range(0, 3)) - 2);
			default: begin
				case ($urandom_range(0, 4))
					0: return {1'b0, {(SCORE_W-1){1'b1}}};
					1: return {1'b1, {(SCORE_W-1){1'b0}}};
					2: return '0;
					3: return '1;
					default: return SCORE_W'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [SCORE_W-1:0] pick_bias();
		case ($urandom_range(0, 4))
			0: return {1'b0, {(SCORE_W-1){1'b1}}};
			1: return {1'b1, {(SCORE_W-1){1'b0}}};
			2: return SCORE_W'(int'($urandom_range(0, 8)) - 4);
			default: return SCORE_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Directed table.
	// ------------------------------------------------------------------
	stim_row_t dir_table [$];

	function automatic void add_item(input logic signed [SCORE_W-1:0] lp,
			input logic signed [SCORE_W-1:0] bs, input logic last);
		stim_row_t r;
		r.kind       = STIM_ITEM;
		r.log_prob   = lp;
		r.beam_score = bs;
		r.last       = last;
		r.reg_index  = '0;
		r.reg_data   = '0;
		r.typed      = 1'b0;
		r.winner     = no_winner;
		dir_table = {dir_table, r};
	endfunction

	// A one-element row whose single winner is written out by hand.
	function automatic void add_typed(input logic signed [SCORE_W-1:0] lp,
			input logic signed [SCORE_W-1:0] bs, input logic signed [SCORE_W-1:0] exp_score,
			input logic [TOKEN_W-1:0] exp_token);
		stim_row_t r;
		r.kind            = STIM_ITEM;
		r.log_prob        = lp;
		r.beam_score      = bs;
		r.last            = 1'b1;
		r.reg_index       = '0;
		r.reg_data        = '0;
		r.typed           = 1'b1;
		r.winner.score    = exp_score;
		r.winner.token_id = exp_token;
		r.winner.last     = 1'b1;
		dir_table = {dir_table, r};
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		stim_row_t r;
		r.kind       = STIM_CFG;
		r.log_prob   = '0;
		r.beam_score = '0;
		r.last       = 1'b0;
		r.reg_index  = idx;
		r.reg_data   = data;
		r.typed      = 1'b0;
		r.winner     = no_winner;
		dir_table = {dir_table, r};
	endfunction

	function automatic void build_table();
		// Straight after reset: two beams, no offset. Single-element rows whose
		// sums hit the top and bottom of the range and cancel to zero.
		add_typed(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, '0);
		add_typed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
		add_typed(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, '0);
		// An ordinary row longer than K = 4, with ties on score.
		add_item(10, $urandom, 1'b0);
		add_item(20, $urandom, 1'b0);
		add_item(10, $urandom, 1'b0);
		add_item(30, $urandom, 1'b0);
		add_item(20, $urandom, 1'b0);
		add_item(5, 32'h0002_8000, 1'b1);
		// One beam with the largest offset, so the token numbers wrap.
		add_cfg(CFG_TOKEN_OFFSET, {CFG_W{1'b1}});
		add_cfg(CFG_NUM_BEAMS, CFG_W'(1));
		add_item(100, $urandom, 1'b0);
		add_item(100, $urandom, 1'b0);
		add_item(100, -1, 1'b1);
		// No beams: the row ends without any result.
		add_cfg(CFG_NUM_BEAMS, '0);
		add_item(-7, $urandom, 1'b0);
		add_item(7, 5, 1'b1);
		// Beam count far above the store size, all-ones data, and a short row.
		add_cfg(CFG_NUM_BEAMS, {CFG_W{1'b1}});
		add_cfg(CFG_TOKEN_OFFSET, CFG_W'(18'h20000));
		add_item(32'h7FFF_FFFF, $urandom, 1'b0);
		add_item(32'h8000_0000, $urandom, 1'b0);
		add_item(0, $urandom, 1'b0);
		add_item(-1, $urandom, 1'b0);
		add_item(1, 32'h7FFF_FFFF, 1'b1);
		// Beam count lowered in the middle of a row.
		add_cfg(CFG_NUM_BEAMS, CFG_W'(4));
		add_item(40, $urandom, 1'b0);
		add_item(30, $urandom, 1'b0);
		add_item(20, $urandom, 1'b0);
		add_item(10, $urandom, 1'b0);
		add_cfg(CFG_NUM_BEAMS, CFG_W'(1));
		add_item(15, 0, 1'b1);
	endfunction

	// Rows of random length and content, with the registers moved between rows
	// and occasionally the beam count moved part way through one.
	task automatic run_random();
		int target;
		int k;
		int len;
		int style;
		int split;
		logic signed [SCORE_W-1:0] bs;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_NUM_BEAMS, pick_beams());
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_TOKEN_OFFSET, pick_offset());
			k = kept_limit();
			if (k < 1)
				k = 1;
			case ($urandom_range(0, 9))
				0: len = 1;
				1, 2: len = $urandom_range(1, k);
				3: len = $urandom_range(20, 40);
				default: len = $urandom_range(k, k + 8);
			endcase
			style = $urandom_range(0, 2);
			split = ($urandom_range(0, 7) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
			for (int i = 0; i < len; i++) begin
				if (split != 0 && i == split)
					write_reg(CFG_NUM_BEAMS, pick_beams());
				bs = (i == len - 1) ? pick_bias() : SCORE_W'($urandom);
				send_beat(pick_score(style), bs, i == len - 1, 1'b0, no_winner);
				pace();
			end
			// Now and then, hold the sender off until every expected beat has come back.
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// Checker and watchdog. A beat moves on the input side when start is
	// high with busy low, and on the result side whenever result_valid is
	// high; the watchdog counts cycles in which neither happens.
	// ------------------------------------------------------------------
	int mismatches = 0;
	int quiet      = 0;

	always @(posedge clk) begin : check_results
		winner_t w;
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet = 0;
			else
				quiet++;
			if (result_valid) begin
				if (winners_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: score %h token_id %h last %b",
							score, token_id, last_result);
				end else begin
					w = winners_due.pop_front();
					if (w.score !== score || w.token_id !== token_id || w.last !== last_result) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: want score %h token_id %h last %b, got %h %h %b",
								w.score, w.token_id, w.last, score, token_id, last_result);
					end
				end
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", quiet);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, directed table, then random rows.
	// ------------------------------------------------------------------
	initial begin
		build_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == STIM_CFG) begin
				write_reg(dir_table[i].reg_index, dir_table[i].reg_data);
			end else begin
				send_beat(dir_table[i].log_prob, dir_table[i].beam_score, dir_table[i].last,
					dir_table[i].typed, dir_table[i].winner);
				pace();
			end
		end

		run_random();

		wait_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0 && winners_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
